// ===== src/rstat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Running statistics table package
// Beat types, operation codes and fixed field widths used by the front end, back end, top and testbench.
// ----------------------------------------------------------------------------
package rstat_pkg;

  localparam int unsigned CountOutW  = 21;
  localparam int unsigned MeanOutW   = 24;
  localparam int unsigned VarOutW    = 39;
  localparam int unsigned RootOutW   = 24;
  localparam int unsigned SampleOutW = 16;

  typedef enum logic [1:0] {
    OP_ACCUMULATE = 2'd0,
    OP_CLEAR      = 2'd1,
    OP_REPORT     = 2'd2,
    OP_RESERVED   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         slot;
    logic signed [15:0] sample;
  } item_t;

  typedef struct packed {
    logic [20:0]        sample_count;
    logic signed [23:0] mean_q8;
    logic [38:0]        variance_q8;
    logic [23:0]        stddev_q8;
    logic [38:0]        mean_variance_q8;
    logic [23:0]        mean_stddev_q8;
    logic signed [15:0] minimum;
    logic signed [15:0] maximum;
    logic               empty_res;
    logic               saturated;
  } result_t;

endpackage
`default_nettype wire

// ===== src/rstat_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Running statistics divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rstat_divider #(
  parameter int unsigned DW = 59,
  parameter int unsigned CW = 21
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [CW-1:0] divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [DW-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_q;
  logic [CW-1:0]   dvs_q;
  logic [CW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [CW:0]     rem_sh, rem_sub;
  logic            ge;

  // The dividend register shifts left and takes quotient bits at its low end.
  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], ge};
      rem_q <= ge ? CW'(rem_sub) : CW'(rem_sh);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule
`default_nettype wire

// ===== src/rstat_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Running statistics square root
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rstat_sqrt #(
  parameter int unsigned RTW = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [2*RTW-1:0] radicand_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [RTW-1:0]        root_o
);

  localparam int unsigned CntW = $clog2(RTW + 1);

  logic [2*RTW-1:0] rad_q;
  logic [RTW:0]     rem_q;
  logic [RTW-1:0]   root_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [RTW+2:0]   rem_sh, trial, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, rad_q[2*RTW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RTW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*RTW-3:0], 2'b00};
      rem_q  <= ge ? (RTW+1)'(rem_sub) : (RTW+1)'(rem_sh);
      root_q <= {root_q[RTW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// ===== src/rstat_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Running statistics front end
// Accepts command beats, drops those that do nothing, squares the sample
// and queues the rest for the back end.
// ----------------------------------------------------------------------------
module rstat_front #(
  parameter int unsigned NUM_SLOTS   = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire rstat_pkg::item_t  item_i,
  output logic                   busy_o,
  output logic                   head_valid_o,
  output rstat_pkg::item_t       head_item_o,
  output logic [2*SAMPLE_BITS-1:0] head_square_o,
  input  wire logic              pop_i
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned QD    = 4;
  localparam int unsigned PtrW  = 2;

  rstat_pkg::item_t       item_mem_q [QD];
  logic [2*SB-1:0]        sq_mem_q   [QD];
  logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]          cnt_q;
  logic                   accept, useful, push;
  logic signed [SB-1:0]   smp;
  logic [SB-1:0]          mag;

  assign busy_o  = cnt_q == (PtrW+1)'(QD);
  assign accept  = start_i && !busy_o;
  // Reserved codes and slots past the table end have no effect at all.
  assign useful  = (item_i.op != rstat_pkg::OP_RESERVED) &&
                   (32'(item_i.slot) < NUM_SLOTS);
  assign push    = accept && useful;

  assign smp = SB'(item_i.sample);
  assign mag = smp[SB-1] ? SB'(-smp) : SB'(smp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      item_mem_q[wr_ptr_q] <= item_i;
      sq_mem_q[wr_ptr_q]   <= mag * mag;
    end
  end

  assign head_valid_o  = cnt_q != '0;
  assign head_item_o   = item_mem_q[rd_ptr_q];
  assign head_square_o = sq_mem_q[rd_ptr_q];

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("queue popped while empty");
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QD)) else $error("queue count overflow");
  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !pop_i) |=> busy_o) else $error("full queue lost an entry");

endmodule
`default_nettype wire

// ===== src/rstat_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Running statistics back end
// Holds the slot table, folds samples in and sequences the report math.
// ----------------------------------------------------------------------------
module rstat_back #(
  parameter int unsigned NUM_SLOTS   = 16,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_LOG2  = 20
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   head_valid_i,
  input  wire rstat_pkg::item_t       head_item_i,
  input  wire logic [2*SAMPLE_BITS-1:0] head_square_i,
  output logic                        pop_o,
  output logic                        done_o,
  output rstat_pkg::result_t          result_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned CL    = COUNT_LOG2;
  localparam int unsigned CNTW  = CL + 1;
  localparam int unsigned SW    = SB + CL;
  localparam int unsigned QW    = 2 * SB + CL - 1;
  localparam int unsigned QBW   = SB + 8;
  localparam int unsigned VW    = 2 * SB + 7;
  localparam int unsigned DDW   = QW + 8;
  localparam int unsigned RTW   = SB + 8;
  localparam int unsigned DEPTH = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
  localparam int unsigned SIW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MEAN  = 7'b0000010,
    S_FIRST = 7'b0000100,
    S_VAR   = 7'b0001000,
    S_MVAR  = 7'b0010000,
    S_MSQRT = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CNTW-1:0]      cnt_q  [DEPTH];
  logic signed [SW-1:0] sum_q  [DEPTH];
  logic [QW-1:0]        ssq_q  [DEPTH];
  logic signed [SB-1:0] min_q  [DEPTH];
  logic signed [SB-1:0] max_q  [DEPTH];
  logic                 drop_q [DEPTH];

  // Snapshot of the reported slot and intermediate results.
  logic [CNTW-1:0]      n_q;
  logic                 neg_q;
  logic [QW-1:0]        ssqs_q;
  logic signed [SB-1:0] mins_q, maxs_q;
  logic                 drops_q;
  logic [QBW-1:0]       mq_q;
  logic [2*QBW-1:0]     msq_q;
  logic [VW-1:0]        first_q, var_q, mvar_q;
  logic [RTW-1:0]       sd_q;

  logic                 done_q;
  rstat_pkg::result_t   res_q;
  rstat_pkg::result_t   res_empty;

  logic [SIW-1:0]       idx;
  logic signed [SB-1:0] smp;
  logic                 pop, is_acc, is_clr, is_rpt;

  logic                 div_start, div_busy, div_done;
  logic [DDW-1:0]       div_dvd, div_quot;
  logic                 sq_start, sq_busy, sq_done;
  logic [2*RTW-1:0]     sq_rad;
  logic [RTW-1:0]       sq_root;

  logic [2*QBW-1:0]     first_ext, second;
  logic [VW-1:0]        var_d;
  logic [SW-1:0]        smag_d;
  logic signed [QBW:0]  mean_full;

  assign pop    = (state_q == S_IDLE) && head_valid_i;
  assign pop_o  = pop;
  assign idx    = SIW'(head_item_i.slot);
  assign smp    = SB'(head_item_i.sample);
  assign is_acc = pop && (head_item_i.op == rstat_pkg::OP_ACCUMULATE);
  assign is_clr = pop && (head_item_i.op == rstat_pkg::OP_CLEAR);
  assign is_rpt = pop && (head_item_i.op == rstat_pkg::OP_REPORT);

  assign smag_d    = sum_q[idx][SW-1] ? SW'(-sum_q[idx]) : SW'(sum_q[idx]);
  assign first_ext = (2*QBW)'(first_q);
  assign second    = msq_q >> 8;
  assign var_d     = (first_ext > second) ? VW'(first_ext - second) : '0;
  assign mean_full = neg_q ? -$signed({1'b0, mq_q}) : $signed({1'b0, mq_q});

  always_comb begin
    res_empty           = '0;
    res_empty.empty_res = 1'b1;
  end

  // Table update: an accumulate reads its slot and writes it back in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        cnt_q[i]  <= '0;
        sum_q[i]  <= '0;
        ssq_q[i]  <= '0;
        min_q[i]  <= '0;
        max_q[i]  <= '0;
        drop_q[i] <= 1'b0;
      end
    end else if (is_clr) begin
      cnt_q[idx]  <= '0;
      sum_q[idx]  <= '0;
      ssq_q[idx]  <= '0;
      min_q[idx]  <= '0;
      max_q[idx]  <= '0;
      drop_q[idx] <= 1'b0;
    end else if (is_acc) begin
      if (cnt_q[idx][CL]) begin
        drop_q[idx] <= 1'b1;
      end else begin
        cnt_q[idx] <= cnt_q[idx] + 1'b1;
        sum_q[idx] <= sum_q[idx] + SW'(smp);
        ssq_q[idx] <= ssq_q[idx] + QW'(head_square_i);
        if (cnt_q[idx] == '0 || smp < min_q[idx]) min_q[idx] <= smp;
        if (cnt_q[idx] == '0 || smp > max_q[idx]) max_q[idx] <= smp;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = DDW'({smag_d, 8'b0});
    sq_start  = 1'b0;
    sq_rad    = (2*RTW)'({var_d, 8'b0});
    unique case (state_q)
      S_IDLE: begin
        if (is_rpt && cnt_q[idx] != '0) begin
          div_start = 1'b1;
          state_d   = S_MEAN;
        end
      end
      S_MEAN: begin
        if (div_done) state_d = S_FIRST;
      end
      S_FIRST: begin
        if (div_done) state_d = S_VAR;
      end
      S_VAR: begin
        div_start = 1'b1;
        div_dvd   = DDW'(var_d);
        sq_start  = 1'b1;
        state_d   = S_MVAR;
      end
      S_MVAR: begin
        if (div_done) begin
          sq_start = 1'b1;
          sq_rad   = (2*RTW)'({VW'(div_quot), 8'b0});
          state_d  = S_MSQRT;
        end
      end
      S_MSQRT: begin
        if (sq_done) state_d = S_HOLD;
      end
      S_HOLD: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // The second division shares the divider, so it starts when the first one signals done.
    if (state_q == S_MEAN && div_done) begin
      div_start = 1'b1;
      div_dvd   = DDW'({ssqs_q, 8'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (is_rpt && cnt_q[idx] == '0) || (state_q == S_HOLD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_rpt) begin
      n_q     <= cnt_q[idx];
      neg_q   <= sum_q[idx][SW-1];
      ssqs_q  <= ssq_q[idx];
      mins_q  <= min_q[idx];
      maxs_q  <= max_q[idx];
      drops_q <= drop_q[idx];
    end
    if (state_q == S_MEAN && div_done) mq_q <= QBW'(div_quot);
    msq_q <= mq_q * mq_q;
    if (state_q == S_FIRST && div_done) first_q <= VW'(div_quot);
    if (state_q == S_VAR) var_q <= var_d;
    if (state_q == S_MVAR && sq_done) sd_q <= sq_root;
    if (state_q == S_MVAR && div_done) mvar_q <= VW'(div_quot);
    if (is_rpt && cnt_q[idx] == '0) begin
      res_q <= res_empty;
    end else if (state_q == S_MSQRT && sq_done) begin
      res_q.sample_count     <= rstat_pkg::CountOutW'(n_q);
      res_q.mean_q8          <= rstat_pkg::MeanOutW'(mean_full);
      res_q.variance_q8      <= rstat_pkg::VarOutW'(var_q);
      res_q.stddev_q8        <= rstat_pkg::RootOutW'(sd_q);
      res_q.mean_variance_q8 <= rstat_pkg::VarOutW'(mvar_q);
      res_q.mean_stddev_q8   <= rstat_pkg::RootOutW'(sq_root);
      res_q.minimum          <= rstat_pkg::SampleOutW'(mins_q);
      res_q.maximum          <= rstat_pkg::SampleOutW'(maxs_q);
      res_q.empty_res        <= 1'b0;
      res_q.saturated        <= drops_q;
    end
  end

  rstat_divider #(.DW(DDW), .CW(CNTW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_start && state_q == S_IDLE ? cnt_q[idx] : n_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  rstat_sqrt #(.RTW(RTW)) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_rad),
    .busy_o     (sq_busy),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign done_o   = done_q;
  assign result_o = res_q;

  a_div_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_sqrt_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_busy) else $error("square root restarted while busy");
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.empty_res) |-> (result_o.sample_count == '0))
    else $error("empty report carries a count");
  a_pop_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (state_q == S_IDLE || state_q == S_MEAN))
    else $error("back end left idle in an unexpected way");

endmodule
`default_nettype wire

// ===== src/running_statistics_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Running statistics table
// Per-slot count, sum, sum of squares, minimum and maximum with Q.8 reports.
// ----------------------------------------------------------------------------
// Accumulate and clear commands complete at one per cycle while the back end
// is idle: the back end updates a slot by a single read-modify-write. A
// report on an empty slot passes through the queue and answers with a
// registered done_o; any other report occupies the back end while the
// bit-serial divider runs three times in turn and the square root twice,
// the first root alongside the third division. A four-entry
// queue keeps taking commands meanwhile; busy rises when it is full. Each
// result appears for one cycle with done_o and cannot be held off.
module running_statistics_table_top #(
  parameter int unsigned NUM_SLOTS   = 16,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_LOG2  = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire rstat_pkg::item_t   item_i,
  output logic                    done_o,
  output rstat_pkg::result_t      result_o
);

  logic                      head_valid, pop;
  rstat_pkg::item_t          head_item;
  logic [2*SAMPLE_BITS-1:0]  head_square;

  rstat_front #(.NUM_SLOTS(NUM_SLOTS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .item_i        (item_i),
    .busy_o        (busy),
    .head_valid_o  (head_valid),
    .head_item_o   (head_item),
    .head_square_o (head_square),
    .pop_i         (pop)
  );

  rstat_back #(
    .NUM_SLOTS   (NUM_SLOTS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_LOG2  (COUNT_LOG2)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_item_i   (head_item),
    .head_square_i (head_square),
    .pop_o         (pop),
    .done_o        (done_o),
    .result_o      (result_o)
  );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Running statistics table testbench
// Drives beats of all four op codes with random gaps, predicts every
// report from its own copy of the slot table and checks each result field.
// ----------------------------------------------------------------------------

class stats_scoreboard;

  localparam int unsigned NumSlots  = 16;
  localparam longint unsigned CountLimit = 64'd1 << 20;

  longint unsigned   cnt_q[NumSlots];
  longint            sum_q[NumSlots];
  longint unsigned   sumsq_q[NumSlots];
  logic signed [15:0] min_q[NumSlots];
  logic signed [15:0] max_q[NumSlots];
  bit                dropped_q[NumSlots];

  rstat_pkg::result_t expected_reports[$];
  int unsigned        mismatches;

  function new();
    for (int s = 0; s < NumSlots; s++) begin
      wipe_slot(s);
    end
    mismatches = 0;
  endfunction

  function void wipe_slot(int s);
    cnt_q[s]     = 0;
    sum_q[s]     = 0;
    sumsq_q[s]   = 0;
    min_q[s]     = '0;
    max_q[s]     = '0;
    dropped_q[s] = 1'b0;
  endfunction

  static function longint unsigned isqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function rstat_pkg::result_t slot_report(int s);
    rstat_pkg::result_t r;
    longint unsigned n, smag, q, first, second, var_v, mvar, sd, msd;
    r = '0;
    n = cnt_q[s];
    if (n == 0) begin
      r.empty_res = 1'b1;
      return r;
    end
    smag   = (sum_q[s] < 0) ? longint'(-sum_q[s]) : longint'(sum_q[s]);
    q      = (smag << 8) / n;
    first  = (sumsq_q[s] << 8) / n;
    second = (q * q) >> 8;
    var_v  = (first > second) ? first - second : 0;
    mvar   = var_v / n;
    sd     = isqrt(var_v << 8);
    msd    = isqrt(mvar << 8);
    r.sample_count     = n[20:0];
    r.mean_q8          = (sum_q[s] < 0) ? -q[23:0] : q[23:0];
    r.variance_q8      = var_v[38:0];
    r.stddev_q8        = sd[23:0];
    r.mean_variance_q8 = mvar[38:0];
    r.mean_stddev_q8   = msd[23:0];
    r.minimum          = min_q[s];
    r.maximum          = max_q[s];
    r.saturated        = dropped_q[s];
    return r;
  endfunction

  // Called for every accepted input beat.
  function void note_item(rstat_pkg::item_t it);
    int s;
    logic signed [15:0] v;
    longint mag;
    s = int'(it.slot);
    v = it.sample;
    case (rstat_pkg::op_e'(it.op))
      rstat_pkg::OP_ACCUMULATE: begin
        if (cnt_q[s] >= CountLimit) begin
          dropped_q[s] = 1'b1;
        end else begin
          if (cnt_q[s] == 0) begin
            min_q[s] = v;
            max_q[s] = v;
          end else begin
            if (v < min_q[s]) min_q[s] = v;
            if (v > max_q[s]) max_q[s] = v;
          end
          mag = (v < 0) ? -longint'(v) : longint'(v);
          cnt_q[s]   += 1;
          sum_q[s]   += longint'(v);
          sumsq_q[s] += longint'(mag * mag);
        end
      end
      rstat_pkg::OP_CLEAR:  wipe_slot(s);
      rstat_pkg::OP_REPORT: expected_reports.push_back(slot_report(s));
      default: ;
    endcase
  endfunction

  function void check_result(rstat_pkg::result_t got);
    rstat_pkg::result_t exp_r;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat: %p", got);
      return;
    end
    exp_r = expected_reports.pop_front();
    if (got.sample_count !== exp_r.sample_count ||
        got.mean_q8 !== exp_r.mean_q8 ||
        got.variance_q8 !== exp_r.variance_q8 ||
        got.stddev_q8 !== exp_r.stddev_q8 ||
        got.mean_variance_q8 !== exp_r.mean_variance_q8 ||
        got.mean_stddev_q8 !== exp_r.mean_stddev_q8 ||
        got.minimum !== exp_r.minimum ||
        got.maximum !== exp_r.maximum ||
        got.empty_res !== exp_r.empty_res ||
        got.saturated !== exp_r.saturated) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("report mismatch\n  expected %p\n  actual   %p", exp_r, got);
      end
    end
  endfunction

endclass

module tb;

  localparam longint unsigned CycleLimit = 5_000_000;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  rstat_pkg::item_t   item_i;
  logic               done_o;
  rstat_pkg::result_t result_o;

  stats_scoreboard table_model;
  int unsigned     beats_taken;
  longint unsigned cycles;

  running_statistics_table_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      table_model.note_item(item_i);
      beats_taken++;
    end
    if (rst_ni && done_o) begin
      table_model.check_result(result_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Holds start high until the beat is taken; returns on a falling edge.
  task automatic send_beat(rstat_pkg::op_e op, int slot, logic signed [15:0] sample);
    int unsigned seen;
    seen        = beats_taken;
    start       = 1'b1;
    item_i.op     = op;
    item_i.slot   = slot[3:0];
    item_i.sample = sample;
    do @(negedge clk_i); while (beats_taken == seen);
  endtask

  task automatic idle_gap();
    int unsigned roll, len;
    roll = $urandom_range(99);
    if (roll < 65) return;
    len = (roll < 95) ? $urandom_range(1, 3) : $urandom_range(20, 80);
    start = 1'b0;
    repeat (len) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return 16'sh8000;
    if (roll == 1) return 16'sh7fff;
    if (roll < 5) return 16'(int'($urandom_range(0, 40)) - 20);
    return 16'($urandom());
  endfunction

  initial begin
    int unsigned roll;
    int          hot_slot;
    table_model  = new();
    beats_taken  = 0;
    cycles       = 0;
    start        = 1'b0;
    item_i       = '0;
    rst_ni       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty slot, extremes, single sample, unused op code, clear.
    send_beat(rstat_pkg::OP_REPORT, 0, 0);
    send_beat(rstat_pkg::OP_ACCUMULATE, 1, 16'sh7fff);
    send_beat(rstat_pkg::OP_ACCUMULATE, 1, 16'sh8000);
    send_beat(rstat_pkg::OP_ACCUMULATE, 1, 16'sh8000);
    send_beat(rstat_pkg::OP_REPORT, 1, 0);
    send_beat(rstat_pkg::OP_ACCUMULATE, 2, -16'sd7);
    send_beat(rstat_pkg::OP_REPORT, 2, 0);
    send_beat(rstat_pkg::OP_RESERVED, 1, 16'sh5555);
    send_beat(rstat_pkg::OP_RESERVED, 15, 16'shaaaa);
    send_beat(rstat_pkg::OP_REPORT, 1, 0);
    send_beat(rstat_pkg::OP_CLEAR, 1, 0);
    send_beat(rstat_pkg::OP_REPORT, 1, 0);
    send_beat(rstat_pkg::OP_ACCUMULATE, 15, 0);
    send_beat(rstat_pkg::OP_ACCUMULATE, 15, 16'sh7fff);
    send_beat(rstat_pkg::OP_REPORT, 15, 16'sh7fff);
    send_beat(rstat_pkg::OP_CLEAR, 15, 0);
    send_beat(rstat_pkg::OP_REPORT, 15, 0);

    // Random traffic, concentrated on a few slots so statistics build up.
    for (int i = 0; i < 700; i++) begin
      idle_gap();
      hot_slot = ($urandom_range(3) == 0) ? int'($urandom_range(15))
                                          : int'($urandom_range(3));
      roll = $urandom_range(99);
      if (roll < 72) send_beat(rstat_pkg::OP_ACCUMULATE, hot_slot, pick_sample());
      else if (roll < 88) send_beat(rstat_pkg::OP_REPORT, hot_slot, 16'($urandom()));
      else if (roll < 95) send_beat(rstat_pkg::OP_CLEAR, hot_slot, 16'($urandom()));
      else send_beat(rstat_pkg::OP_RESERVED, hot_slot, 16'($urandom()));
    end
    start = 1'b0;

    while (table_model.expected_reports.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (table_model.mismatches == 0 && table_model.expected_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rstat_pkg.sv
src/rstat_divider.sv
src/rstat_sqrt.sv
src/rstat_front.sv
src/rstat_back.sv
src/running_statistics_table_top.sv
test/tb.sv
